[hdl/bptc_pkg.sv]
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; every other file of the block imports this package.
package bptc_pkg;

  localparam int RAW_W  = 24;  // raw sensor conversion width
  localparam int CAL_W  = 16;  // calibration word width
  localparam int IDX_W  = 3;   // configuration register index width
  localparam int DT_W   = 25;  // temperature difference, signed
  localparam int TEMP_W = 20;  // temperature in 0.01 degC, signed
  localparam int WIDE_W = 40;  // offset, sensitivity and their corrections, signed
  localparam int OUT_W  = 32;  // result field width

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_PRESS_SENS = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESS_OFF  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TC    = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFF_TC     = 3'd3;
  localparam logic [IDX_W-1:0] REG_TREF       = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMP_TC    = 3'd5;

  // Temperature thresholds in 0.01 degC.
  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -20'sd1500;
  localparam logic signed [TEMP_W-1:0] COLD_OFS  = 20'sd1500;

  typedef struct packed {
    logic [CAL_W-1:0] c1;  // pressure sensitivity
    logic [CAL_W-1:0] c2;  // pressure offset
    logic [CAL_W-1:0] c3;  // sensitivity temperature coefficient
    logic [CAL_W-1:0] c4;  // offset temperature coefficient
    logic [CAL_W-1:0] c5;  // reference temperature
    logic [CAL_W-1:0] c6;  // temperature coefficient
  } cal_t;

  // First-order values handed from the front end to the correction stages.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] t2;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
    logic        [RAW_W-1:0]  d1;
  } front_t;

  // Fully corrected values handed to the pressure stages.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
    logic        [RAW_W-1:0]  d1;
  } corr_t;

endpackage

[hdl/baro_pressure_temp_compensation.sv]
// Top level of the barometric second-order compensation pipeline.
// Depends on bptc_pkg, bptc_cfg, bptc_front, bptc_corr and bptc_press.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    raw temperature and raw pressure
//   out_     master     out_tvalid/out_tready  temperature and pressure, 0.01 units
//   cfg_     slave      cfg_valid/cfg_ready    register index and 16-bit word
//
// The pipeline is nine register stages deep, and a new item can be taken
// every cycle unless a stalled result holds the pipeline.
// All stages advance together whenever the output register is empty or
// being drained, so a stalled result holds every stage in place.
// rst_n clears the valid bits and the calibration words; data registers
// are not reset. Calibration words are always writable (cfg_ready is high).
module baro_pressure_temp_compensation (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input items
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [47:0]                 in_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
  // Result items
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata,  // [31:0] temperature_centi, [63:32] pressure_centi
  // Calibration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bptc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bptc_pkg::CAL_W-1:0]  cfg_data
);
  import bptc_pkg::*;

  cal_t             cal;
  logic             en;
  logic             front_vld, corr_vld;
  front_t           front_data;
  corr_t            corr_data;
  logic [OUT_W-1:0] temp_out, press_out;

  // Whole-pipeline advance: the output register is free or its item leaves now.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  bptc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cal     (cal)
  );

  // Stages 1 to 3: dT, its products, first-order TEMP, OFF, SENS and T2.
  bptc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .d2_i   (in_tdata[RAW_W-1:0]),
    .d1_i   (in_tdata[2*RAW_W-1:RAW_W]),
    .cal    (cal),
    .vld_o  (front_vld),
    .data_o (front_data)
  );

  // Stages 4 to 6: low-temperature corrections.
  bptc_corr u_corr (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (front_vld),
    .data_i (front_data),
    .vld_o  (corr_vld),
    .data_o (corr_data)
  );

  // Stages 7 to 9: pressure product, final shifts and the output register.
  bptc_press u_press (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (corr_vld),
    .data_i  (corr_data),
    .vld_o   (out_tvalid),
    .temp_o  (temp_out),
    .press_o (press_out)
  );

  assign out_tdata = {press_out, temp_out};

endmodule

[hdl/bptc_cfg.sv]
// Calibration register file, written through the configuration channel.
// Depends on bptc_pkg for the register indexes and the cal_t type.
module bptc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [bptc_pkg::IDX_W-1:0]  wr_idx,
  input  logic [bptc_pkg::CAL_W-1:0]  wr_data,
  output bptc_pkg::cal_t              cal
);
  import bptc_pkg::*;

  cal_t cal_r;
  cal_t cal_nxt;

  always_comb begin
    cal_nxt = cal_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_PRESS_SENS: cal_nxt.c1 = wr_data;
        REG_PRESS_OFF:  cal_nxt.c2 = wr_data;
        REG_SENS_TC:    cal_nxt.c3 = wr_data;
        REG_OFF_TC:     cal_nxt.c4 = wr_data;
        REG_TREF:       cal_nxt.c5 = wr_data;
        REG_TEMP_TC:    cal_nxt.c6 = wr_data;
        default:        cal_nxt = cal_r;  // indexes beyond the list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

[hdl/bptc_front.sv]
// Front end: temperature difference, the four products on it, and the
// first-order temperature, offset, sensitivity and T2 term (three stages).
// Depends on bptc_pkg.
module bptc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [bptc_pkg::RAW_W-1:0] d2_i,
  input  logic [bptc_pkg::RAW_W-1:0] d1_i,
  input  bptc_pkg::cal_t             cal,
  output logic                       vld_o,
  output bptc_pkg::front_t           data_o
);
  import bptc_pkg::*;

  logic [2:0] vld_r;

  // Stage 1
  logic signed [DT_W-1:0] dt_r, dt_nxt;
  logic [RAW_W-1:0]       d1_s1_r;
  // Stage 2
  logic signed [41:0]     p6_r, p6_nxt;
  logic signed [41:0]     p4_r, p4_nxt;
  logic signed [41:0]     p3_r, p3_nxt;
  logic signed [49:0]     pdd_r, pdd_nxt;
  logic [RAW_W-1:0]       d1_s2_r;
  // Stage 3
  front_t                 s3_r, s3_nxt;

  logic signed [CAL_W:0]  c6s, c4s, c3s;

  assign dt_nxt = $signed({1'b0, d2_i}) - $signed({1'b0, cal.c5, 8'b0});

  assign c6s = $signed({1'b0, cal.c6});
  assign c4s = $signed({1'b0, cal.c4});
  assign c3s = $signed({1'b0, cal.c3});

  assign p6_nxt  = dt_r * c6s;
  assign p4_nxt  = dt_r * c4s;
  assign p3_nxt  = dt_r * c3s;
  assign pdd_nxt = dt_r * dt_r;

  always_comb begin
    s3_nxt.temp = TEMP_REF + TEMP_W'(p6_r >>> 23);
    s3_nxt.t2   = TEMP_W'(pdd_r >>> 31);
    s3_nxt.off  = WIDE_W'($signed({1'b0, cal.c2, 16'b0})) + WIDE_W'(p4_r >>> 7);
    s3_nxt.sens = WIDE_W'($signed({1'b0, cal.c1, 15'b0})) + WIDE_W'(p3_r >>> 8);
    s3_nxt.d1   = d1_s2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dt_r    <= dt_nxt;
      d1_s1_r <= d1_i;
      p6_r    <= p6_nxt;
      p4_r    <= p4_nxt;
      p3_r    <= p3_nxt;
      pdd_r   <= pdd_nxt;
      d1_s2_r <= d1_s1_r;
      s3_r    <= s3_nxt;
    end
  end

  assign vld_o  = vld_r[2];
  assign data_o = s3_r;

endmodule

[hdl/bptc_corr.sv]
// Second-order correction below 20 degC and the extra term below -15 degC
// (three stages: squares, correction terms, subtraction). Depends on bptc_pkg.
module bptc_corr (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  bptc_pkg::front_t  data_i,
  output logic              vld_o,
  output bptc_pkg::corr_t   data_o
);
  import bptc_pkg::*;

  logic [2:0] vld_r;

  // Stage 4
  logic signed [TEMP_W-1:0] x, y;
  logic signed [WIDE_W-1:0] dsq_r, dsq_nxt;
  logic signed [WIDE_W-1:0] esq_r, esq_nxt;
  logic                     warm_lt_r, cold_lt_r;
  corr_t                    s4_r, s4_nxt;
  // Stage 5
  logic signed [WIDE_W-1:0] off2_r, off2_nxt;
  logic signed [WIDE_W-1:0] sens2_r, sens2_nxt;
  logic signed [WIDE_W-1:0] d5, e7, e11;
  corr_t                    s5_r;
  // Stage 6
  corr_t                    s6_r, s6_nxt;

  assign x       = data_i.temp - TEMP_REF;
  assign y       = data_i.temp + COLD_OFS;
  assign dsq_nxt = x * x;
  assign esq_nxt = y * y;

  always_comb begin
    s4_nxt      = '{temp: data_i.temp, off: data_i.off, sens: data_i.sens, d1: data_i.d1};
    if (data_i.temp < TEMP_REF) begin
      s4_nxt.temp = data_i.temp - data_i.t2;
    end
  end

  // Constant multiples by shift and add.
  assign d5  = (dsq_r <<< 2) + dsq_r;
  assign e7  = (esq_r <<< 3) - esq_r;
  assign e11 = (esq_r <<< 3) + (esq_r <<< 1) + esq_r;

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (warm_lt_r) begin
      off2_nxt  = d5 >>> 1;
      sens2_nxt = d5 >>> 2;
      if (cold_lt_r) begin
        off2_nxt  = (d5 >>> 1) + e7;
        sens2_nxt = (d5 >>> 2) + (e11 >>> 1);
      end
    end
  end

  always_comb begin
    s6_nxt      = s5_r;
    s6_nxt.off  = s5_r.off - off2_r;
    s6_nxt.sens = s5_r.sens - sens2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsq_r     <= dsq_nxt;
      esq_r     <= esq_nxt;
      warm_lt_r <= data_i.temp < TEMP_REF;
      cold_lt_r <= data_i.temp < TEMP_COLD;
      s4_r      <= s4_nxt;
      off2_r    <= off2_nxt;
      sens2_r   <= sens2_nxt;
      s5_r      <= s4_r;
      s6_r      <= s6_nxt;
    end
  end

  assign vld_o  = vld_r[2];
  assign data_o = s6_r;

endmodule

[hdl/bptc_press.sv]
// Pressure stages: split product of raw pressure and sensitivity, product
// sum, and the output register with the final shifts. Depends on bptc_pkg.
module bptc_press (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  bptc_pkg::corr_t             data_i,
  output logic                        vld_o,
  output logic [bptc_pkg::OUT_W-1:0]  temp_o,
  output logic [bptc_pkg::OUT_W-1:0]  press_o
);
  import bptc_pkg::*;

  logic [2:0] vld_r;

  // Stage 7: two partial products on the low and high halves of SENS.
  logic [43:0]              lo_r, lo_nxt;
  logic signed [44:0]       hi_r, hi_nxt;
  logic signed [TEMP_W-1:0] temp_s7_r, temp_s8_r;
  logic signed [WIDE_W-1:0] off_s7_r, off_s8_r;
  // Stage 8
  logic signed [63:0]       prod_r, prod_nxt;
  // Stage 9: output register
  logic signed [63:0]       diff;
  logic [OUT_W-1:0]         temp_r, press_r;

  assign lo_nxt = data_i.d1 * data_i.sens[19:0];
  assign hi_nxt = $signed({1'b0, data_i.d1}) * $signed(data_i.sens[WIDE_W-1:20]);

  assign prod_nxt = (64'(hi_r) <<< 20) + $signed({20'b0, lo_r});

  assign diff = (prod_r >>> 21) - 64'(off_s8_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      temp_s7_r <= data_i.temp;
      off_s7_r  <= data_i.off;
      prod_r    <= prod_nxt;
      temp_s8_r <= temp_s7_r;
      off_s8_r  <= off_s7_r;
      temp_r    <= OUT_W'(temp_s8_r);
      press_r   <= diff[46:15];
    end
  end

  assign vld_o   = vld_r[2];
  assign temp_o  = temp_r;
  assign press_o = press_r;

endmodule

[tb/bptc_checker.sv]
// Scoreboard for the barometric compensation pipeline: watches the calibration,
// input and result channels, predicts each reading and compares it.
// Depends on bptc_pkg for the register indexes, thresholds and cal_t.
module bptc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [47:0]                 in_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [63:0]                 out_tdata,  // [31:0] temperature_centi, [63:32] pressure_centi
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [bptc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bptc_pkg::CAL_W-1:0]  cfg_data,
  output int                          err_count,
  output int                          pending,
  output int                          checked,
  output int                          cold_hits,
  output int                          frigid_hits
);
  import bptc_pkg::*;

  localparam int TEMP_SHIFT  = 23;
  localparam int OFF_SHIFT   = 7;
  localparam int SENS_SHIFT  = 8;
  localparam int T2_SHIFT    = 31;
  localparam int PROD_SHIFT  = 21;
  localparam int PRESS_SHIFT = 15;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic                     cold;
    logic                     frigid;
    logic [RAW_W-1:0]         raw_temp;
    logic [RAW_W-1:0]         raw_press;
    logic signed [OUT_W-1:0]  pressure_centi;
    logic signed [OUT_W-1:0]  temperature_centi;
  } forecast_t;

  cal_t      cal_words;
  forecast_t expected_q[$];

  // Second-order compensation in exact 64-bit signed arithmetic.
  function automatic forecast_t compensate(cal_t c, logic [RAW_W-1:0] d2,
                                           logic [RAW_W-1:0] d1);
    longint    dt, temp, off, sens, t2, off2, sens2, dsq, esq, p;
    forecast_t f;
    dt   = longint'(d2) - (longint'(c.c5) <<< 8);
    temp = longint'(TEMP_REF) + ((dt * longint'(c.c6)) >>> TEMP_SHIFT);
    off  = (longint'(c.c2) <<< 16) + ((dt * longint'(c.c4)) >>> OFF_SHIFT);
    sens = (longint'(c.c1) <<< 15) + ((dt * longint'(c.c3)) >>> SENS_SHIFT);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    f.cold   = (temp < longint'(TEMP_REF));
    f.frigid = (temp < longint'(TEMP_COLD));
    if (f.cold) begin
      dsq   = (temp - longint'(TEMP_REF)) * (temp - longint'(TEMP_REF));
      t2    = (dt * dt) >>> T2_SHIFT;
      off2  = (5 * dsq) >>> 1;
      sens2 = (5 * dsq) >>> 2;
      if (f.frigid) begin
        esq   = (temp + longint'(COLD_OFS)) * (temp + longint'(COLD_OFS));
        off2  = off2 + 7 * esq;
        sens2 = sens2 + ((11 * esq) >>> 1);
      end
    end
    temp = temp - t2;
    off  = off - off2;
    sens = sens - sens2;
    p = ((((longint'(d1) * sens) >>> PROD_SHIFT) - off) >>> PRESS_SHIFT);
    f.raw_temp          = d2;
    f.raw_press         = d1;
    f.temperature_centi = temp[OUT_W-1:0];
    f.pressure_centi    = p[OUT_W-1:0];
    return f;
  endfunction

  task automatic report(string msg);
    err_count = err_count + 1;
    if (err_count <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    forecast_t f;
    logic signed [OUT_W-1:0] got_temp, got_press;
    if (!rst_n) begin
      cal_words = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRESS_SENS: cal_words.c1 = cfg_data;
          REG_PRESS_OFF:  cal_words.c2 = cfg_data;
          REG_SENS_TC:    cal_words.c3 = cfg_data;
          REG_OFF_TC:     cal_words.c4 = cfg_data;
          REG_TREF:       cal_words.c5 = cfg_data;
          REG_TEMP_TC:    cal_words.c6 = cfg_data;
          default: ;  // spare indexes are ignored by the block
        endcase
      end
      if (in_tvalid && in_tready) begin
        f = compensate(cal_words, in_tdata[23:0], in_tdata[47:24]);
        expected_q.push_back(f);
        if (f.cold) cold_hits = cold_hits + 1;
        if (f.frigid) frigid_hits = frigid_hits + 1;
      end
      if (out_tvalid && out_tready) begin
        got_temp  = out_tdata[31:0];
        got_press = out_tdata[63:32];
        if (expected_q.size() == 0) begin
          report($sformatf("result T %0d P %0d with no item outstanding",
                           got_temp, got_press));
        end else begin
          f = expected_q.pop_front();
          checked = checked + 1;
          if (got_temp !== f.temperature_centi)
            report($sformatf("temperature_centi %0d, expected %0d (raw T %0d P %0d)",
                             got_temp, f.temperature_centi, f.raw_temp, f.raw_press));
          if (got_press !== f.pressure_centi)
            report($sformatf("pressure_centi %0d, expected %0d (raw T %0d P %0d)",
                             got_press, f.pressure_centi, f.raw_temp, f.raw_press));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for the barometric second-order compensation pipeline.
// Depends on bptc_pkg, the block baro_pressure_temp_compensation and bptc_checker.
module tb_top;
  import bptc_pkg::*;

  localparam int ITEM_COUNT   = 1550;
  localparam int BLOCK_ITEMS  = 50;       // items per calibration set in the random part
  localparam int DRAIN_CYCLES = 12;       // pipeline is nine stages deep, plus margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  // Indexes the block has no register behind; writes there must change nothing.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [CAL_W-1:0]  cfg_data   = '0;

  int err_count, pending, checked, cold_hits, frigid_hits;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int cal_sets      = 0;
  int cycle_count   = 0;

  // The calibration last loaded, kept here only to aim raw temperatures at
  // the correction thresholds.
  cal_t cal_now = '0;

  baro_pressure_temp_compensation u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bptc_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .err_count   (err_count),
    .pending     (pending),
    .checked     (checked),
    .cold_hits   (cold_hits),
    .frigid_hits (frigid_hits)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random; the percentage changes between phases,
  // and the last phase never stalls.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("FAIL baro_pressure_temp_compensation");
      $finish;
    end
  end

  // One register write. cfg_valid is left high so that back-to-back writes
  // never lower and raise it in the same step; load_cal lowers it at the end.
  // Handshake inputs are sampled at the falling edge, where they are settled.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] value);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Loads all six calibration words. With spares set, junk goes to the two
  // unused indexes afterwards, which the block must ignore.
  task automatic load_cal(cal_t c, bit spares);
    write_reg(REG_PRESS_SENS, c.c1);
    write_reg(REG_PRESS_OFF,  c.c2);
    write_reg(REG_SENS_TC,    c.c3);
    write_reg(REG_OFF_TC,     c.c4);
    write_reg(REG_TREF,       c.c5);
    write_reg(REG_TEMP_TC,    c.c6);
    if (spares) begin
      write_reg(REG_SPARE_LO, CAL_W'($urandom_range(16'hFFFF)));
      write_reg(REG_SPARE_HI, CAL_W'($urandom_range(16'hFFFF)));
    end
    cfg_valid <= 1'b0;
    cal_now  = c;
    cal_sets = cal_sets + 1;
  endtask

  // Offers one item, after a random idle gap when the sender is set to idle.
  // tvalid stays high on return so the next item can follow with no bubble.
  task automatic send_item(logic [RAW_W-1:0] raw_temp, logic [RAW_W-1:0] raw_press);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {raw_press, raw_temp};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    items_sent = items_sent + 1;
  endtask

  // Stops offering items and waits until every reading has come back, then
  // lets the pipeline settle before calibration may change.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Picks a raw temperature whose first-order temperature lands on the
  // target (in 0.01 degC), give or take a few counts of jitter. Lands on the
  // rail when the target lies beyond what 24 bits can reach.
  function automatic logic [RAW_W-1:0] aim_temp(longint target, int jitter);
    longint dt, d2;
    if (cal_now.c6 == 0) return RAW_W'($urandom_range(RAW_MAX));
    dt = ((target - longint'(TEMP_REF)) * 64'sd8388608) / longint'(cal_now.c6);
    d2 = longint'(cal_now.c5) * 256 + dt + jitter;
    if (d2 < 0) d2 = 0;
    else if (d2 > longint'(RAW_MAX)) d2 = longint'(RAW_MAX);
    return d2[RAW_W-1:0];
  endfunction

  function automatic logic [CAL_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return CAL_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic cal_t random_cal();
    cal_t c;
    c.c1 = random_word();
    c.c2 = random_word();
    c.c3 = random_word();
    c.c4 = random_word();
    c.c5 = random_word();
    c.c6 = random_word();
    return c;
  endfunction

  function automatic logic [RAW_W-1:0] random_raw();
    case ($urandom_range(15))
      0:       return '0;
      1:       return RAW_MAX;
      default: return RAW_W'($urandom_range(RAW_MAX));
    endcase
  endfunction

  // Most random temperatures are aimed at the two correction thresholds or
  // just around them; the rest are spread over the full 24-bit range.
  function automatic logic [RAW_W-1:0] pick_raw_temp();
    int j;
    j = int'($urandom_range(8));
    j = j - 4;
    case ($urandom_range(9))
      0, 1, 2: return random_raw();
      3:       return aim_temp(2000, 0);
      4:       return aim_temp(1999, 0);
      5:       return aim_temp(-1500, 0);
      6:       return aim_temp(-1501, 0);
      7:       return aim_temp(2000 - int'($urandom_range(4000)), j);
      default: return aim_temp(-1500 - int'($urandom_range(6000)), j);
    endcase
  endfunction

  initial begin
    cal_t typical;
    int   phase, n;
    typical = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. All calibration words are zero after reset, so the
    // formulas run on an empty calibration first.
    send_item('0, '0);
    send_item(RAW_MAX, RAW_MAX);
    drain();

    // Every calibration word at its maximum, raw values at both rails and in
    // alternating bit patterns; the spare indexes get written as well.
    load_cal('1, 1'b1);
    send_item('0, '0);
    send_item(RAW_MAX, RAW_MAX);
    send_item('0, RAW_MAX);
    send_item(RAW_MAX, '0);
    send_item(24'hAAAAAA, 24'h555555);
    send_item(24'h555555, 24'hAAAAAA);
    drain();

    // A typical sensor calibration, with temperatures placed exactly on both
    // sides of 20.00 degC and of -15.00 degC.
    load_cal(typical, 1'b1);
    send_item(24'd8569150, 24'd9085466);
    send_item(aim_temp(2000, 0), 24'd9085466);
    send_item(aim_temp(1999, 0), 24'd9085466);
    send_item(aim_temp(-1500, 0), 24'd9085466);
    send_item(aim_temp(-1501, 0), 24'd9085466);
    send_item(aim_temp(-4000, 0), RAW_MAX);
    send_item(aim_temp(8500, 0), '0);
    drain();

    // Random part in three phases: sender idling lightly while the receiver
    // stalls heavily, then the reverse, then full throughput. Calibration is
    // reloaded between blocks, always with the pipeline empty.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (n = 0; n < ITEM_COUNT / 3; n++) begin
        if (n % BLOCK_ITEMS == 0) begin
          drain();
          load_cal(random_cal(), $urandom_range(3) == 0);
        end
        send_item(pick_raw_temp(), random_raw());
      end
    end
    drain();

    $display("sent %0d items over %0d calibration sets, spare indexes included",
             items_sent, cal_sets);
    $display("compared %0d readings: %0d below 20.00 degC, %0d below -15.00 degC",
             checked, cold_hits, frigid_hits);
    if (err_count == 0) begin
      $display("PASS baro_pressure_temp_compensation");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAIL baro_pressure_temp_compensation");
    end
    $finish;
  end

endmodule
